[hdl/tcr_pkg.sv]
// shared types and constants of the topsis closeness ranker
// used by tcr_ctrl, tcr_datapath and topsis_closeness_ranker
package tcr_pkg;

    localparam int MAX_ALTERNATIVES = 16;
    localparam int MAX_CRITERIA     = 4;
    localparam int NUM_INPUTS       = 4;

    localparam int VALUE_W    = 32;
    localparam int WEIGHT_W   = 16;
    localparam int Q_W        = 16;
    localparam int SUM_W      = 64;
    localparam int SQ_SHIFT   = 6;
    localparam int DIST_SQ_W  = 34;
    localparam int ROOT_W     = 18;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 5;

    localparam logic [SUM_W-1:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BENEFIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CRIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ALT    = 3'd6;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd16384;
    localparam logic [3:0]          MASK_RESET   = 4'hf;
    localparam logic [2:0]          NC_RESET     = 3'd4;
    localparam logic [4:0]          NA_RESET     = 5'd4;

    localparam logic [1:0] SQ_SRC_COL   = 2'd0;
    localparam logic [1:0] SQ_SRC_BEST  = 2'd1;
    localparam logic [1:0] SQ_SRC_WORST = 2'd2;

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic       load_row;
        logic       sq_mul;
        logic       sq_acc;
        logic       sq_load;
        logic [1:0] sq_src;
        logic       sq_step;
        logic       nrm_setup;
        logic       div_step;
        logic       nrm_wr;
        logic       nrm_first;
        logic       col_end;
        logic       dst_clr;
        logic       dst_acc;
        logic       db_capture;
        logic       cl_setup;
        logic       clr_sums;
    } cmd_t;

    typedef struct packed {
        logic [2:0] num_criteria;
        logic [4:0] num_alternatives;
    } status_t;

endpackage

[hdl/tcr_ram.sv]
// generic single-port ram with registered read
// no dependencies
module tcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/tcr_datapath.sv]
// datapath: config registers, row and weighted-value stores, column sums,
// shared square root and divider units; depends on tcr_pkg and tcr_ram
module tcr_datapath #(
    parameter int MAX_ALTERNATIVES = tcr_pkg::MAX_ALTERNATIVES,
    parameter int MAX_CRITERIA     = tcr_pkg::MAX_CRITERIA,
    localparam int RA = $clog2(MAX_ALTERNATIVES),
    localparam int CA = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  tcr_pkg::value_t                  values [tcr_pkg::NUM_INPUTS],
    input  tcr_pkg::cmd_t                    cmd,
    input  logic [RA-1:0]                    row_idx,
    input  logic [CA-1:0]                    col_idx,
    output tcr_pkg::status_t                 status,
    output logic [tcr_pkg::Q_W-1:0]          closeness,
    output logic [tcr_pkg::Q_W-1:0]          dist_best,
    output logic [tcr_pkg::Q_W-1:0]          dist_worst
);

    localparam int AW    = RA + CA;
    localparam int DEPTH = MAX_ALTERNATIVES * (2 ** CA);

    logic [tcr_pkg::WEIGHT_W-1:0] weight_reg [4];
    logic [3:0]                   mask_reg;
    logic [2:0]                   nc_reg;
    logic [4:0]                   na_reg;

    tcr_pkg::value_t              hold_reg [MAX_CRITERIA];
    logic [2*tcr_pkg::VALUE_W-1:0] prod_reg;
    logic [tcr_pkg::SUM_W-1:0]    sum_reg [MAX_CRITERIA];

    logic [tcr_pkg::SUM_W-1:0]    rad_reg;
    logic [tcr_pkg::SUM_W-1:0]    root_reg;
    logic [tcr_pkg::SUM_W-1:0]    bitv_reg;

    logic [31:0]                  rem_reg;
    logic [15:0]                  dlow_reg;
    logic [31:0]                  divisor_reg;
    logic [15:0]                  quo_reg;
    logic                         q_zero_reg;
    logic                         q_sat_reg;

    logic [tcr_pkg::Q_W-1:0]      mx_reg;
    logic [tcr_pkg::Q_W-1:0]      mn_reg;
    logic [tcr_pkg::Q_W-1:0]      best_reg  [MAX_CRITERIA];
    logic [tcr_pkg::Q_W-1:0]      worst_reg [MAX_CRITERIA];
    logic [tcr_pkg::DIST_SQ_W-1:0] sb_reg;
    logic [tcr_pkg::DIST_SQ_W-1:0] sw_reg;
    logic [tcr_pkg::ROOT_W-1:0]   db_reg;
    logic [tcr_pkg::ROOT_W-1:0]   dw_reg;

    logic [AW-1:0]                addr;
    logic [1:0]                   col4;
    tcr_pkg::value_t              row_rdata;
    logic [tcr_pkg::Q_W-1:0]      wv_rdata;
    logic [tcr_pkg::Q_W-1:0]      wv_wdata;
    logic [tcr_pkg::SUM_W-1:0]    sq_src_val;
    logic [tcr_pkg::SUM_W-1:0]    root_trial;
    logic [32:0]                  div_trial;
    logic [31:0]                  col_root;
    logic [tcr_pkg::Q_W-1:0]      norm_val;
    logic [31:0]                  wprod;
    logic [tcr_pkg::Q_W-1:0]      eb;
    logic [tcr_pkg::Q_W-1:0]      ew;
    logic [31:0]                  eb_sq;
    logic [31:0]                  ew_sq;
    logic [tcr_pkg::ROOT_W-1:0]   dw_now;
    logic [tcr_pkg::ROOT_W-1:0]   tot;

    assign addr = {row_idx, col_idx};
    assign col4 = 2'(col_idx);

    tcr_ram #(
        .WIDTH (tcr_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (cmd.sq_mul),
        .addr  (addr),
        .wdata (hold_reg[col_idx]),
        .rdata (row_rdata)
    );

    tcr_ram #(
        .WIDTH (tcr_pkg::Q_W),
        .DEPTH (DEPTH)
    ) u_wv_ram (
        .clk   (clk),
        .we    (cmd.nrm_wr),
        .addr  (addr),
        .wdata (wv_wdata),
        .rdata (wv_rdata)
    );

    always_comb
    begin
        case (cmd.sq_src)
            tcr_pkg::SQ_SRC_COL:   sq_src_val = sum_reg[col_idx];
            tcr_pkg::SQ_SRC_BEST:  sq_src_val = tcr_pkg::SUM_W'(sb_reg);
            tcr_pkg::SQ_SRC_WORST: sq_src_val = tcr_pkg::SUM_W'(sw_reg);
            default:               sq_src_val = '0;
        endcase
    end

    assign root_trial = root_reg + bitv_reg;
    assign div_trial  = {rem_reg, dlow_reg[15]};
    assign col_root   = root_reg[31:0];

    assign norm_val = q_zero_reg ? '0 : (q_sat_reg ? 16'hffff : quo_reg);
    assign wprod    = norm_val * weight_reg[col4];
    assign wv_wdata = wprod[31:16];

    assign eb = (wv_rdata >= best_reg[col_idx]) ? wv_rdata - best_reg[col_idx]
                                                : best_reg[col_idx] - wv_rdata;
    assign ew = (wv_rdata >= worst_reg[col_idx]) ? wv_rdata - worst_reg[col_idx]
                                                 : worst_reg[col_idx] - wv_rdata;
    assign eb_sq = eb * eb;
    assign ew_sq = ew * ew;

    assign dw_now = root_reg[tcr_pkg::ROOT_W-1:0];
    assign tot    = db_reg + dw_now;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
            begin
                weight_reg[k] <= tcr_pkg::WEIGHT_RESET;
            end
            mask_reg <= tcr_pkg::MASK_RESET;
            nc_reg   <= tcr_pkg::NC_RESET;
            na_reg   <= tcr_pkg::NA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcr_pkg::CFG_WEIGHT_0: weight_reg[0] <= cfg_data;
                tcr_pkg::CFG_WEIGHT_1: weight_reg[1] <= cfg_data;
                tcr_pkg::CFG_WEIGHT_2: weight_reg[2] <= cfg_data;
                tcr_pkg::CFG_WEIGHT_3: weight_reg[3] <= cfg_data;
                tcr_pkg::CFG_BENEFIT:  mask_reg <= cfg_data[3:0];
                tcr_pkg::CFG_NUM_CRIT: nc_reg   <= cfg_data[2:0];
                tcr_pkg::CFG_NUM_ALT:  na_reg   <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign status.num_criteria     = nc_reg;
    assign status.num_alternatives = na_reg;

    // column sums and ideal values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CRITERIA; k++)
            begin
                sum_reg[k]   <= '0;
                best_reg[k]  <= '0;
                worst_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.sq_acc)
            begin
                sum_reg[col_idx] <= sum_reg[col_idx] + (prod_reg >> tcr_pkg::SQ_SHIFT);
            end
            if (cmd.clr_sums)
            begin
                for (int k = 0; k < MAX_CRITERIA; k++)
                begin
                    sum_reg[k] <= '0;
                end
            end
            if (cmd.col_end)
            begin
                if (mask_reg[col4])
                begin
                    best_reg[col_idx]  <= mx_reg;
                    worst_reg[col_idx] <= mn_reg;
                end
                else
                begin
                    best_reg[col_idx]  <= mn_reg;
                    worst_reg[col_idx] <= mx_reg;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            for (int k = 0; k < MAX_CRITERIA; k++)
            begin
                hold_reg[k] <= values[k];
            end
        end
        if (cmd.sq_mul)
        begin
            prod_reg <= hold_reg[col_idx] * hold_reg[col_idx];
        end

        if (cmd.sq_load)
        begin
            rad_reg  <= sq_src_val;
            root_reg <= '0;
            bitv_reg <= tcr_pkg::ROOT_BIT0;
        end
        else if (cmd.sq_step)
        begin
            if (rad_reg >= root_trial)
            begin
                rad_reg  <= rad_reg - root_trial;
                root_reg <= (root_reg >> 1) + bitv_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bitv_reg <= bitv_reg >> 2;
        end

        if (cmd.nrm_setup)
        begin
            rem_reg     <= 32'(row_rdata >> 3);
            dlow_reg    <= {row_rdata[2:0], 13'b0};
            divisor_reg <= col_root;
            q_zero_reg  <= (col_root == '0);
            q_sat_reg   <= ({3'b0, row_rdata} >= {col_root, 3'b0});
        end
        else if (cmd.cl_setup)
        begin
            rem_reg     <= 32'(dw_now);
            dlow_reg    <= '0;
            divisor_reg <= 32'(tot);
            q_zero_reg  <= (tot == '0);
            q_sat_reg   <= (db_reg == '0) && (dw_now != '0);
            dw_reg      <= dw_now;
        end
        else if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, divisor_reg})
            begin
                rem_reg <= 32'(div_trial - {1'b0, divisor_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_trial[31:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            dlow_reg <= {dlow_reg[14:0], 1'b0};
        end

        if (cmd.nrm_wr)
        begin
            if (cmd.nrm_first || wv_wdata > mx_reg)
            begin
                mx_reg <= wv_wdata;
            end
            if (cmd.nrm_first || wv_wdata < mn_reg)
            begin
                mn_reg <= wv_wdata;
            end
        end

        if (cmd.dst_clr)
        begin
            sb_reg <= '0;
            sw_reg <= '0;
        end
        else if (cmd.dst_acc)
        begin
            sb_reg <= sb_reg + tcr_pkg::DIST_SQ_W'(eb_sq);
            sw_reg <= sw_reg + tcr_pkg::DIST_SQ_W'(ew_sq);
        end

        if (cmd.db_capture)
        begin
            db_reg <= root_reg[tcr_pkg::ROOT_W-1:0];
        end
    end

    assign closeness  = q_zero_reg ? '0 : (q_sat_reg ? 16'hffff : quo_reg);
    assign dist_best  = (db_reg > 18'd65535) ? 16'hffff : db_reg[15:0];
    assign dist_worst = (dw_reg > 18'd65535) ? 16'hffff : dw_reg[15:0];

endmodule

[hdl/tcr_ctrl.sv]
// controller state machine: sequences loading, normalization, distances and closeness
// depends on tcr_pkg
module tcr_ctrl #(
    parameter int MAX_ALTERNATIVES = tcr_pkg::MAX_ALTERNATIVES,
    parameter int MAX_CRITERIA     = tcr_pkg::MAX_CRITERIA,
    localparam int RA = $clog2(MAX_ALTERNATIVES),
    localparam int CA = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  tcr_pkg::status_t status,
    output logic             busy,
    output tcr_pkg::cmd_t    cmd,
    output logic [RA-1:0]    row_idx,
    output logic [CA-1:0]    col_idx,
    output logic             done,
    output logic             last,
    output logic [3:0]       alternative_index
);

    localparam int RLW = $clog2(MAX_ALTERNATIVES + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SQ      = 5'd1;
    localparam logic [4:0] S_ACC     = 5'd2;
    localparam logic [4:0] S_CS_INIT = 5'd3;
    localparam logic [4:0] S_CS_RUN  = 5'd4;
    localparam logic [4:0] S_NRM_RD  = 5'd5;
    localparam logic [4:0] S_NRM_SET = 5'd6;
    localparam logic [4:0] S_NRM_DIV = 5'd7;
    localparam logic [4:0] S_NRM_WR  = 5'd8;
    localparam logic [4:0] S_COL_END = 5'd9;
    localparam logic [4:0] S_DST_RD  = 5'd10;
    localparam logic [4:0] S_DST_ACC = 5'd11;
    localparam logic [4:0] S_DB_INIT = 5'd12;
    localparam logic [4:0] S_DB_RUN  = 5'd13;
    localparam logic [4:0] S_DW_INIT = 5'd14;
    localparam logic [4:0] S_DW_RUN  = 5'd15;
    localparam logic [4:0] S_CL_SET  = 5'd16;
    localparam logic [4:0] S_CL_DIV  = 5'd17;
    localparam logic [4:0] S_EMIT    = 5'd18;

    logic [4:0]                  state_reg, state_next;
    logic [RA-1:0]               i_reg, i_next;
    logic [CA-1:0]               j_reg, j_next;
    logic [tcr_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [RLW-1:0]              rows_reg, rows_next;

    logic [31:0] na_eff;
    logic [31:0] nc_eff;
    logic        col_last;
    logic        row_last;
    logic        crit_last;
    logic        root_done;
    logic        div_done;

    always_comb
    begin
        if (status.num_alternatives == '0)
        begin
            na_eff = 32'd1;
        end
        else if (32'(status.num_alternatives) > MAX_ALTERNATIVES)
        begin
            na_eff = 32'(MAX_ALTERNATIVES);
        end
        else
        begin
            na_eff = 32'(status.num_alternatives);
        end

        if (status.num_criteria == '0)
        begin
            nc_eff = 32'd1;
        end
        else if (32'(status.num_criteria) > MAX_CRITERIA)
        begin
            nc_eff = 32'(MAX_CRITERIA);
        end
        else
        begin
            nc_eff = 32'(status.num_criteria);
        end
    end

    assign col_last  = (32'(j_reg) + 32'd1 == nc_eff);
    assign crit_last = (32'(j_reg) == MAX_CRITERIA - 1);
    assign row_last  = (32'(i_reg) + 32'd1 == 32'(rows_reg));
    assign root_done = (32'(cnt_reg) == tcr_pkg::ROOT_STEPS - 1);
    assign div_done  = (32'(cnt_reg) == tcr_pkg::DIV_STEPS - 1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        rows_next  = rows_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_row = 1'b1;
                    j_next       = '0;
                    state_next   = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_mul = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.sq_acc = 1'b1;
                if (crit_last)
                begin
                    j_next    = '0;
                    rows_next = rows_reg + 1'b1;
                    if (32'(rows_reg) + 32'd1 >= na_eff)
                    begin
                        state_next = S_CS_INIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SQ;
                end
            end
            S_CS_INIT:
            begin
                cmd.sq_load = 1'b1;
                cmd.sq_src  = tcr_pkg::SQ_SRC_COL;
                cnt_next    = '0;
                state_next  = S_CS_RUN;
            end
            S_CS_RUN:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (root_done)
                begin
                    i_next     = '0;
                    state_next = S_NRM_RD;
                end
            end
            S_NRM_RD:
            begin
                state_next = S_NRM_SET;
            end
            S_NRM_SET:
            begin
                cmd.nrm_setup = 1'b1;
                cnt_next      = '0;
                state_next    = S_NRM_DIV;
            end
            S_NRM_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_done)
                begin
                    state_next = S_NRM_WR;
                end
            end
            S_NRM_WR:
            begin
                cmd.nrm_wr    = 1'b1;
                cmd.nrm_first = (i_reg == '0);
                if (row_last)
                begin
                    state_next = S_COL_END;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_NRM_RD;
                end
            end
            S_COL_END:
            begin
                cmd.col_end = 1'b1;
                if (col_last)
                begin
                    cmd.dst_clr = 1'b1;
                    i_next      = '0;
                    j_next      = '0;
                    state_next  = S_DST_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CS_INIT;
                end
            end
            S_DST_RD:
            begin
                state_next = S_DST_ACC;
            end
            S_DST_ACC:
            begin
                cmd.dst_acc = 1'b1;
                if (col_last)
                begin
                    j_next     = '0;
                    state_next = S_DB_INIT;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_DST_RD;
                end
            end
            S_DB_INIT:
            begin
                cmd.sq_load = 1'b1;
                cmd.sq_src  = tcr_pkg::SQ_SRC_BEST;
                cnt_next    = '0;
                state_next  = S_DB_RUN;
            end
            S_DB_RUN:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (root_done)
                begin
                    state_next = S_DW_INIT;
                end
            end
            S_DW_INIT:
            begin
                cmd.db_capture = 1'b1;
                cmd.sq_load    = 1'b1;
                cmd.sq_src     = tcr_pkg::SQ_SRC_WORST;
                cnt_next       = '0;
                state_next     = S_DW_RUN;
            end
            S_DW_RUN:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (root_done)
                begin
                    state_next = S_CL_SET;
                end
            end
            S_CL_SET:
            begin
                cmd.cl_setup = 1'b1;
                cnt_next     = '0;
                state_next   = S_CL_DIV;
            end
            S_CL_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (row_last)
                begin
                    cmd.clr_sums = 1'b1;
                    rows_next    = '0;
                    i_next       = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.dst_clr = 1'b1;
                    i_next      = i_reg + 1'b1;
                    j_next      = '0;
                    state_next  = S_DST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            rows_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            rows_reg  <= rows_next;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign col_idx = j_reg;
    assign row_idx = (state_reg == S_IDLE || state_reg == S_SQ || state_reg == S_ACC)
                     ? rows_reg[RA-1:0] : i_reg;

    assign done              = (state_reg == S_EMIT);
    assign last              = done && row_last;
    assign alternative_index = 4'(i_reg);

endmodule

[hdl/topsis_closeness_ranker.sv]
// top level of the topsis closeness ranker
// depends on tcr_pkg, tcr_ctrl, tcr_datapath and tcr_ram
//
// One row is taken per start beat while busy is low; each row then keeps the
// block busy while one shared 32x32 multiplier squares the criteria into
// the column sums. When the batch is complete the block stays busy for the
// whole computation: per used column a column root (a 32-step shared
// square-root unit) and per row a 16-step division in the shared divider,
// then per row the squared distances summed over the used criteria, two
// 32-step roots and one 16-step division, followed by its result beat.
// Each result is shown for exactly one cycle with done high and cannot be
// held off; last marks the final row of the batch.
module topsis_closeness_ranker #(
    parameter int MAX_ALTERNATIVES = tcr_pkg::MAX_ALTERNATIVES,
    parameter int MAX_CRITERIA     = tcr_pkg::MAX_CRITERIA
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    value_0,
    input  logic [31:0]                    value_1,
    input  logic [31:0]                    value_2,
    input  logic [31:0]                    value_3,
    output logic                           done,
    output logic [3:0]                     alternative_index,
    output logic [15:0]                    closeness,
    output logic [15:0]                    dist_best,
    output logic [15:0]                    dist_worst,
    output logic                           last
);

    localparam int RA = $clog2(MAX_ALTERNATIVES);
    localparam int CA = (MAX_CRITERIA > 1) ? $clog2(MAX_CRITERIA) : 1;

    tcr_pkg::value_t  values [tcr_pkg::NUM_INPUTS];
    tcr_pkg::cmd_t    cmd;
    tcr_pkg::status_t status;
    logic [RA-1:0]    row_idx;
    logic [CA-1:0]    col_idx;

    assign values[0] = value_0;
    assign values[1] = value_1;
    assign values[2] = value_2;
    assign values[3] = value_3;

    tcr_ctrl #(
        .MAX_ALTERNATIVES (MAX_ALTERNATIVES),
        .MAX_CRITERIA     (MAX_CRITERIA)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .status            (status),
        .busy              (busy),
        .cmd               (cmd),
        .row_idx           (row_idx),
        .col_idx           (col_idx),
        .done              (done),
        .last              (last),
        .alternative_index (alternative_index)
    );

    tcr_datapath #(
        .MAX_ALTERNATIVES (MAX_ALTERNATIVES),
        .MAX_CRITERIA     (MAX_CRITERIA)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .values     (values),
        .cmd        (cmd),
        .row_idx    (row_idx),
        .col_idx    (col_idx),
        .status     (status),
        .closeness  (closeness),
        .dist_best  (dist_best),
        .dist_worst (dist_worst)
    );

endmodule
